// ----- rtl/core/sobx_pkg.sv -----
// Package with shared constants for the Sobel horizontal gradient filter.
`default_nettype none

package sobx_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed field widths.
    localparam int GRAD_BITS   = 11;
    localparam int ROW_BITS    = 13;
    localparam int IWIDTH_BITS = 12;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // Register reset values.
    localparam logic [IWIDTH_BITS-1:0] WIDTH_RST  = 12'd640;
    localparam logic [ROW_BITS-1:0]    HEIGHT_RST = 13'd480;
    localparam logic                   MODE_RST   = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/sobel_x_gradient_filter.sv -----
// Streaming 3x3 Sobel x-gradient filter with line memory, window and APB registers.
// Pipeline: input stage (beat and line-memory read), then result register.
// Throughput: one pixel beat per cycle while result_ready does not stall the result
// register, as the line memory reads and writes once a cycle.
// Reset: width 640, height 480, saturating mode and cleared counters; the line
// memory needs no clearing pass, as unwritten rows are never selected.
`default_nettype none

module sobel_x_gradient_filter #(
    parameter int MAX_WIDTH  = sobx_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = sobx_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Pixel input channel
    input  wire logic                           pixel_valid,
    output logic                                pixel_ready,
    input  wire logic [PIXEL_BITS-1:0]          pixel_value,
    input  wire logic                           flush,
    // Result output channel
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic signed [sobx_pkg::GRAD_BITS-1:0] gradient,
    output logic                                frame_last,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sobx_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [sobx_pkg::DATA_BITS-1:0] pwdata,
    output logic [sobx_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import sobx_pkg::*;

    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int GW    = PIXEL_BITS + 3;
    localparam int PB    = PIXEL_BITS;

    // Configuration registers
    logic [IWIDTH_BITS-1:0] image_width_reg;
    logic [ROW_BITS-1:0]    image_height_reg;
    logic                   output_mode_reg;
    logic                   cfg_write;
    logic                   geom_write;

    // Position counters of the next input beat
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    // Effective geometry
    logic [31:0]         iw_wide;
    logic [WBITS-1:0]    w_eff;
    logic [ROW_BITS-1:0] h_eff;
    logic [ROW_BITS:0]   h_plus1;
    logic [ROW_BITS:0]   row_wide;
    logic [WBITS-1:0]    col_inc;

    // Decoded flags of the incoming beat
    logic          in_accept;
    logic          c_zero, c_ge2, r_ge1, r_ge2, r_le_h, r_le_h1;
    logic          have_in, last_in;
    logic [PB-1:0] low_in;

    // Line memory: upper row in the high half, middle row in the low half
    logic [2*PB-1:0] line_mem [MAX_WIDTH];
    logic [2*PB-1:0] pair_rd_reg;

    // Input stage registers
    logic          s1_valid_reg;
    logic          s1_adv;
    logic [CW-1:0] s1_col_reg;
    logic [PB-1:0] s1_low_reg;
    logic          s1_c_zero_reg, s1_c_ge2_reg;
    logic          s1_use_up_reg, s1_use_mid_reg;
    logic          s1_have_reg, s1_last_reg;

    // Window columns: older (left candidate) and newest
    logic [PB-1:0] cola_up_reg, cola_mid_reg, cola_low_reg;
    logic [PB-1:0] colb_up_reg, colb_mid_reg, colb_low_reg;

    // Gradient datapath
    logic [PB-1:0]        new_up, new_mid;
    logic [PB-1:0]        r_up, r_mid, r_low, l_up, l_mid, l_low;
    logic signed [PB:0]   d_up, d_mid, d_low;
    logic signed [GW-1:0] g_sum, g_sat;
    logic signed [GW-1:0] pix_max;

    // Result register
    logic                        out_valid_reg;
    logic signed [GRAD_BITS-1:0] gradient_reg;
    logic                        frame_last_reg;

    // APB write decode
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign geom_write = cfg_write && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT));

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            output_mode_reg  <= MODE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_WIDTH:  image_width_reg  <= pwdata[IWIDTH_BITS-1:0];
                REG_HEIGHT: image_height_reg <= pwdata[ROW_BITS-1:0];
                REG_MODE:   output_mode_reg  <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // APB read mux
    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = DATA_BITS'(image_width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(image_height_reg);
            REG_MODE:   prdata = DATA_BITS'(output_mode_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective width and height: width clamped to 2..MAX_WIDTH, height zero acts as one.
    always_comb
    begin
        iw_wide = 32'(image_width_reg);
        if (iw_wide < 32'd2)
        begin
            w_eff = WBITS'(2);
        end
        else if (iw_wide > 32'(MAX_WIDTH))
        begin
            w_eff = WBITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WBITS'(iw_wide);
        end
        h_eff   = (image_height_reg == '0) ? ROW_BITS'(1) : image_height_reg;
        h_plus1 = {1'b0, h_eff} + (ROW_BITS+1)'(1);
    end

    // Handshake: the input stage moves on when the result register is free.
    assign s1_adv      = !out_valid_reg || result_ready;
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign in_accept   = pixel_valid && pixel_ready;

    // Decode the position of the incoming beat.
    always_comb
    begin
        row_wide = {1'b0, row_reg};
        c_zero   = (col_reg == '0);
        c_ge2    = (col_reg >= CW'(2)) && (CW > 1);
        r_ge1    = (row_reg != '0);
        r_ge2    = (row_reg >= ROW_BITS'(2));
        r_le_h   = (row_reg <= h_eff);
        r_le_h1  = (row_wide <= h_plus1);
        last_in  = c_zero && r_ge2 && r_le_h1 && (row_wide == h_plus1);
        have_in  = (c_zero && r_ge2 && r_le_h1) || (!c_zero && r_ge1 && r_le_h);
        low_in   = (flush || (row_reg >= h_eff)) ? '0 : pixel_value;
    end

    // Next position: wraps at the row end and restarts after the frame's last result.
    always_comb
    begin
        col_inc  = WBITS'(col_reg) + WBITS'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (last_in)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = CW'(col_inc);
        end
    end

    // Position counters; a geometry write starts a new frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (geom_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memory: read the column pair on accept, write back the shifted pair
    // when the beat leaves the input stage.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pair_rd_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg && s1_adv)
        begin
            line_mem[s1_col_reg] <= {pair_rd_reg[PB-1:0], s1_low_reg};
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg     <= col_reg;
            s1_low_reg     <= low_in;
            s1_c_zero_reg  <= c_zero;
            s1_c_ge2_reg   <= c_ge2;
            s1_use_up_reg  <= r_ge2;
            s1_use_mid_reg <= r_ge1;
            s1_have_reg    <= have_in;
            s1_last_reg    <= last_in;
        end
    end

    // Gradient: right column minus left column, weighted 1-2-1.
    always_comb
    begin
        new_up  = s1_use_up_reg  ? pair_rd_reg[2*PB-1:PB] : '0;
        new_mid = s1_use_mid_reg ? pair_rd_reg[PB-1:0]    : '0;

        // At the row start the right neighbor lies outside the image.
        r_up  = s1_c_zero_reg ? '0 : new_up;
        r_mid = s1_c_zero_reg ? '0 : new_mid;
        r_low = s1_c_zero_reg ? '0 : s1_low_reg;

        // In the second column the left neighbor lies outside the image.
        l_up  = (s1_c_zero_reg || s1_c_ge2_reg) ? cola_up_reg  : '0;
        l_mid = (s1_c_zero_reg || s1_c_ge2_reg) ? cola_mid_reg : '0;
        l_low = (s1_c_zero_reg || s1_c_ge2_reg) ? cola_low_reg : '0;

        d_up  = $signed({1'b0, r_up})  - $signed({1'b0, l_up});
        d_mid = $signed({1'b0, r_mid}) - $signed({1'b0, l_mid});
        d_low = $signed({1'b0, r_low}) - $signed({1'b0, l_low});
        g_sum = GW'(d_up) + (GW'(d_mid) <<< 1) + GW'(d_low);

        // Optional clamp to the unsigned pixel range.
        pix_max = GW'((1 << PIXEL_BITS) - 1);
        g_sat   = g_sum;
        if (output_mode_reg)
        begin
            if (g_sum < 0)
            begin
                g_sat = '0;
            end
            else if (g_sum > pix_max)
            begin
                g_sat = pix_max;
            end
        end
    end

    // Window shift as the beat leaves the input stage.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            cola_up_reg  <= colb_up_reg;
            cola_mid_reg <= colb_mid_reg;
            cola_low_reg <= colb_low_reg;
            colb_up_reg  <= new_up;
            colb_mid_reg <= new_mid;
            colb_low_reg <= s1_low_reg;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_have_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg && s1_have_reg)
        begin
            gradient_reg   <= GRAD_BITS'(g_sat);
            frame_last_reg <= s1_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign gradient     = gradient_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

// ----- verif/tb_sobel_x_gradient_filter.sv -----
// Self-checking testbench for the streaming Sobel x-gradient filter.
module tb_sobel_x_gradient_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import sobx_pkg::*;

    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int PIX_MAX       = (1 << PIXEL_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES = 12;
    localparam int SETTLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS  = 2000;

    typedef struct packed {
        logic [PIXEL_BITS_DEF-1:0] value;
        logic                      flush;
    } pixel_beat_t;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] gradient;
        logic                        frame_last;
    } grad_beat_t;

    // Clock, reset and block ports.
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          pixel_valid  = 1'b0;
    logic                          pixel_ready;
    logic [PIXEL_BITS_DEF-1:0]     pixel_value  = '0;
    logic                          flush        = 1'b0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic signed [GRAD_BITS-1:0]   gradient;
    logic                          frame_last;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [ADDR_BITS-1:0]          paddr        = '0;
    logic [DATA_BITS-1:0]          pwdata       = '0;
    logic [DATA_BITS-1:0]          prdata;
    logic                          pready;

    // Stimulus and checking bookkeeping.
    pixel_beat_t pending_pixels[$];
    grad_beat_t  expected_grads[$];
    pixel_beat_t next_beat;
    grad_beat_t  oldest_grad;
    int          pixels_queued   = 0;
    int          pixels_accepted = 0;
    int          mismatch_count  = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;

    // Predictor copy of the registers and the filter state.
    logic [IWIDTH_BITS-1:0] model_width  = WIDTH_RST;
    logic [ROW_BITS-1:0]    model_height = HEIGHT_RST;
    logic                   model_mode   = MODE_RST;
    logic [7:0]             upper_row [LINE_DEPTH];
    logic [7:0]             middle_row [LINE_DEPTH];
    logic [7:0]             win_upper [3];
    logic [7:0]             win_middle [3];
    logic [7:0]             win_lower [3];
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;

    sobel_x_gradient_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .flush        (flush),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .gradient     (gradient),
        .frame_last   (frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Weighted 1-2-1 sum of one window column.
    function automatic int column_sum(input int k);
        return int'(win_upper[k]) + 2 * int'(win_middle[k]) + int'(win_lower[k]);
    endfunction

    // Advances the filter state by one pixel and queues the gradient it yields.
    function automatic void predict_gradient(input pixel_beat_t beat);
        int unsigned w, h, c, r, ci;
        logic [7:0]  px, up_px, mid_px;
        int          g;
        bit          produced, last;
        grad_beat_t  res;
        w = (model_width < 2) ? 2 : ((model_width > LINE_DEPTH) ? LINE_DEPTH : model_width);
        h = (model_height == 0) ? 1 : model_height;
        c = col_pos;
        r = row_pos;
        ci = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
        px = (beat.flush || r >= h) ? 8'd0 : beat.value;
        g = 0;
        produced = 1'b0;
        last = 1'b0;
        // Column zero closes the previous row, whose right neighbor lies outside.
        if (c == 0 && r >= 2 && r <= h + 1)
        begin
            g = -column_sum(1);
            produced = 1'b1;
            last = (r == h + 1);
        end
        // Line stores shift down one row at this column.
        up_px = (r >= 2) ? upper_row[ci] : 8'd0;
        mid_px = (r >= 1) ? middle_row[ci] : 8'd0;
        upper_row[ci] = middle_row[ci];
        middle_row[ci] = px;
        // Window slides left and takes the new column on the right.
        win_upper[0] = win_upper[1];
        win_upper[1] = win_upper[2];
        win_upper[2] = up_px;
        win_middle[0] = win_middle[1];
        win_middle[1] = win_middle[2];
        win_middle[2] = mid_px;
        win_lower[0] = win_lower[1];
        win_lower[1] = win_lower[2];
        win_lower[2] = px;
        // Centre one row up and one column left; the left edge sees zeros.
        if (c >= 1 && r >= 1 && r <= h)
        begin
            g = column_sum(2) - ((c >= 2) ? column_sum(0) : 0);
            produced = 1'b1;
        end
        // Position of the next pixel.
        if (last)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            col_pos = c & 32'h7FF;
            row_pos = r & 32'h1FFF;
        end
        if (produced)
        begin
            if (model_mode)
            begin
                if (g < 0)
                    g = 0;
                if (g > PIX_MAX)
                    g = PIX_MAX;
            end
            res.gradient = g[GRAD_BITS-1:0];
            res.frame_last = last;
            expected_grads.push_back(res);
        end
    endfunction

    // Pixel driver: predicts each accepted beat and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel_value <= '0;
            flush <= 1'b0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                predict_gradient({pixel_value, flush});
                pixels_accepted++;
            end
            if (!pixel_valid || pixel_ready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                    pixel_value <= next_beat.value;
                    flush <= next_beat.flush;
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_grads.size() == 0)
                begin
                    $error("unexpected result beat: gradient %0d, frame_last %0b",
                           gradient, frame_last);
                    mismatch_count++;
                end
                else
                begin
                    oldest_grad = expected_grads.pop_front();
                    if (gradient !== oldest_grad.gradient)
                    begin
                        $error("gradient: expected %0d, actual %0d",
                               $signed(oldest_grad.gradient), gradient);
                        mismatch_count++;
                    end
                    if (frame_last !== oldest_grad.frame_last)
                    begin
                        $error("frame_last: expected %0b, actual %0b",
                               oldest_grad.frame_last, frame_last);
                        mismatch_count++;
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Waits until every pixel is taken and every gradient is back, then lets the
    // pipeline drain pixels that produce no result.
    task automatic settle();
        int waited;
        waited = 0;
        while ((pixels_accepted != pixels_queued || expected_grads.size() != 0)
               && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pixels_accepted != pixels_queued || expected_grads.size() != 0)
        begin
            $error("%0d pixels and %0d gradients still outstanding",
                   pixels_queued - pixels_accepted, expected_grads.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access until pready.
    task automatic write_register(input logic [1:0] index, input logic [DATA_BITS-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // A geometry write restarts the frame; the line stores keep their data.
        case (index)
            REG_WIDTH:
            begin
                model_width = data[IWIDTH_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_HEIGHT:
            begin
                model_height = data[ROW_BITS-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_MODE: model_mode = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int w, input int h, input bit mode);
        settle();
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_MODE, mode);
    endtask

    task automatic queue_pixel(input int value, input bit fl);
        pixel_beat_t b;
        b.value = value[PIXEL_BITS_DEF-1:0];
        b.flush = fl;
        pending_pixels.push_back(b);
        pixels_queued++;
    endtask

    // Random pixel, biased toward the extremes of the range.
    function automatic int random_pixel();
        case ($urandom_range(3))
            0: return 0;
            1: return PIX_MAX;
            default: return $urandom_range(PIX_MAX);
        endcase
    endfunction

    // Queues a frame, drain row and one more beat; a cut frame stops after cut_at pixels.
    // Noisy frames carry stray flush bits and drain beats with random content.
    task automatic queue_frame(input int w, input int h, input int cut_at, input bit noisy);
        int total;
        total = w * (h + 1) + 1;
        for (int n = 0; n < total && n != cut_at; n++)
        begin
            if (n < w * h)
                queue_pixel(random_pixel(), noisy && $urandom_range(15) == 0);
            else if (noisy)
                queue_pixel($urandom_range(PIX_MAX), $urandom_range(1));
            else
                queue_pixel($urandom_range(PIX_MAX), 1'b1);
        end
    endtask

    // Main sequence.
    initial
    begin
        int random_start, reg_w, reg_h, eff_w, eff_h, cut, frames;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int k = 0; k < 3; k++)
        begin
            win_upper[k] = '0;
            win_middle[k] = '0;
            win_lower[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 36;
        recv_idle_pct = 47;

        // Full-scale edges: column one bright gives +1020 and -1020 around it.
        configure(4, 3, 1'b0);
        for (int row = 0; row < 3; row++)
        begin
            for (int col = 0; col < 4; col++)
            begin
                // A flush inside the frame counts as a black pixel.
                if (row == 1 && col == 0)
                    queue_pixel(PIX_MAX, 1'b1);
                else
                    queue_pixel((col == 1) ? PIX_MAX : 0, 1'b0);
            end
        end
        // Beats past the last row count as zero with or without flush.
        for (int n = 0; n < 5; n++)
            queue_pixel(PIX_MAX, n >= 3);

        // Width and height of zero act as the smallest frame; saturate both ways.
        configure(0, 0, 1'b1);
        queue_pixel(PIX_MAX, 1'b0);
        queue_pixel(PIX_MAX, 1'b0);
        for (int n = 0; n < 3; n++)
            queue_pixel(PIX_MAX, 1'b1);

        // Width beyond the line store acts as the store depth; only the start
        // of that frame is sent, and the next geometry write restarts it.
        configure(4095, 1, $urandom_range(1));
        queue_frame(LINE_DEPTH, 1, 40, 1'b0);

        // Tallest frame, cut short; the next geometry write restarts it.
        configure(2, 8191, 1'b0);
        queue_frame(2, 8191, 40, 1'b1);

        // Random frames in three idling regimes.
        random_start = pixels_queued;
        while (pixels_queued - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0: reg_w = $urandom_range(1);
                1: reg_w = $urandom_range(64, 25);
                default: reg_w = $urandom_range(12, 2);
            endcase
            case ($urandom_range(7))
                0: reg_h = 0;
                1: reg_h = $urandom_range(12, 8);
                default: reg_h = $urandom_range(5, 1);
            endcase
            configure(reg_w, reg_h, $urandom_range(1));
            if (pixels_queued - random_start < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 47;
            end
            else if (pixels_queued - random_start < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            eff_w = (reg_w < 2) ? 2 : reg_w;
            eff_h = (reg_h == 0) ? 1 : reg_h;
            // Back-to-back frames, now and then one broken off midway.
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++)
            begin
                cut = ($urandom_range(7) == 0) ? $urandom_range(eff_w * (eff_h + 1)) : -1;
                queue_frame(eff_w, eff_h, cut, $urandom_range(3) == 0);
                if (cut >= 0)
                    break;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("sobel_x_gradient_filter: match");
        else
            $display("sobel_x_gradient_filter: mismatch");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("sobel_x_gradient_filter: mismatch");
        $finish;
    end

endmodule
